// ----- rtl/core/key_scanner_with_repeat_fifo_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the key scanner
// Clocked, reset-gated property checks used by the kswr_back event FIFO module.
// ---------------------------------------------------------------------------
`ifndef KEY_SCANNER_WITH_REPEAT_FIFO_ASSERT_SVH
`define KEY_SCANNER_WITH_REPEAT_FIFO_ASSERT_SVH

// same-cycle implication
`define KS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/kswr_pkg.sv -----
// ---------------------------------------------------------------------------
// kswr_pkg
// Types and constants shared by the key scanner modules.
// ---------------------------------------------------------------------------
`default_nettype none

package kswr_pkg;

	localparam int PORT_WIDTH = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int THR_W      = 8;
	localparam int CMDQ_DEPTH = 2;

	localparam logic [PORT_WIDTH-1:0] RST_KEY_MASK   = 16'h0780;
	localparam logic [THR_W-1:0]      RST_THRESHOLD  = 8'd25;
	localparam logic [PORT_WIDTH-1:0] RST_CODE_RIGHT = 16'h0080;
	localparam logic [PORT_WIDTH-1:0] RST_CODE_LEFT  = 16'h0100;
	localparam logic [PORT_WIDTH-1:0] RST_CODE_ENTER = 16'h0200;
	localparam logic [PORT_WIDTH-1:0] RST_CODE_BACK  = 16'h0400;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	localparam logic [2:0] POP_NONE = 3'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_MASK   = 3'd0,
		CFG_THRESHOLD  = 3'd1,
		CFG_CODE_RIGHT = 3'd2,
		CFG_CODE_LEFT  = 3'd3,
		CFG_CODE_ENTER = 3'd4,
		CFG_CODE_BACK  = 3'd5
	} kswr_cfg_idx_t;

	typedef enum logic [1:0] {
		EV_RIGHT = 2'd0,
		EV_LEFT  = 2'd1,
		EV_ENTER = 2'd2,
		EV_BACK  = 2'd3
	} kswr_ev_t;

	typedef struct packed {
		logic                  action;
		logic [PORT_WIDTH-1:0] port_bits;
	} kswr_in_t;

	typedef struct packed {
		logic [2:0] pop_code;
		logic       queue_empty;
		logic       event_dropped;
		logic [4:0] queued_count;
	} kswr_out_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} kswr_cfg_wr_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic     is_pop;
		logic     has_ev;
		kswr_ev_t ev;
	} kswr_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/kswr_front.sv -----
// ---------------------------------------------------------------------------
// kswr_front
// Config registers, edge detect and auto-repeat; classifies each transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module kswr_front
	import kswr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire kswr_cfg_wr_t cfg,
	input  wire logic         accept,
	input  wire kswr_in_t     in_data,
	output kswr_cmd_t         cmd
);

	logic [PORT_WIDTH-1:0] key_mask_q;
	logic [THR_W-1:0]      threshold_q;
	logic [PORT_WIDTH-1:0] code_right_q;
	logic [PORT_WIDTH-1:0] code_left_q;
	logic [PORT_WIDTH-1:0] code_enter_q;
	logic [PORT_WIDTH-1:0] code_back_q;
	logic [PORT_WIDTH-1:0] held_q;
	logic [THR_W-1:0]      stable_q;

	logic [PORT_WIDTH-1:0] pressed;
	logic [PORT_WIDTH-1:0] trig;
	logic [PORT_WIDTH-1:0] pat;
	logic [THR_W-1:0]      stable_inc;
	logic [THR_W-1:0]      stable_nxt;
	logic                  rep;
	logic                  hit;
	kswr_ev_t              ev;

	assign pressed = (in_data.port_bits & key_mask_q) ^ key_mask_q;
	assign trig    = pressed & ~held_q;

	always_comb begin
		stable_inc = (stable_q == {THR_W{1'b1}}) ? stable_q : stable_q + THR_W'(1);
		stable_inc = (pressed == held_q) ? stable_inc : '0;
		rep        = (stable_inc > threshold_q) && (pressed != '0) && (trig == '0);
		stable_nxt = rep ? '0 : stable_inc;
		pat        = rep ? (pressed & key_mask_q) : (trig & key_mask_q);
	end

	// first match wins; repeats only for right and left
	always_comb begin
		hit = 1'b0;
		ev  = EV_RIGHT;
		priority if (pat == '0) begin
			hit = 1'b0;
		end else if (pat == code_right_q) begin
			hit = 1'b1;
			ev  = EV_RIGHT;
		end else if (pat == code_left_q) begin
			hit = 1'b1;
			ev  = EV_LEFT;
		end else if (rep) begin
			hit = 1'b0;
		end else if (pat == code_enter_q) begin
			hit = 1'b1;
			ev  = EV_ENTER;
		end else if (pat == code_back_q) begin
			hit = 1'b1;
			ev  = EV_BACK;
		end else begin
			hit = 1'b0;
		end
	end

	always_comb begin
		cmd.is_pop = (in_data.action == ACT_POP);
		cmd.has_ev = (in_data.action == ACT_SAMPLE) && hit;
		cmd.ev     = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mask_q   <= RST_KEY_MASK;
			threshold_q  <= RST_THRESHOLD;
			code_right_q <= RST_CODE_RIGHT;
			code_left_q  <= RST_CODE_LEFT;
			code_enter_q <= RST_CODE_ENTER;
			code_back_q  <= RST_CODE_BACK;
		end else if (cfg.we) begin
			unique case (kswr_cfg_idx_t'(cfg.idx))
				CFG_KEY_MASK:   key_mask_q   <= cfg.data[PORT_WIDTH-1:0];
				CFG_THRESHOLD:  threshold_q  <= cfg.data[THR_W-1:0];
				CFG_CODE_RIGHT: code_right_q <= cfg.data[PORT_WIDTH-1:0];
				CFG_CODE_LEFT:  code_left_q  <= cfg.data[PORT_WIDTH-1:0];
				CFG_CODE_ENTER: code_enter_q <= cfg.data[PORT_WIDTH-1:0];
				CFG_CODE_BACK:  code_back_q  <= cfg.data[PORT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			stable_q <= '0;
		end else if (accept && (in_data.action == ACT_SAMPLE)) begin
			held_q   <= pressed;
			stable_q <= stable_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/kswr_cmdq.sv -----
// ---------------------------------------------------------------------------
// kswr_cmdq
// Small command queue between the front and back halves.
// ---------------------------------------------------------------------------
`default_nettype none

module kswr_cmdq
	import kswr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire kswr_cmd_t push_cmd,
	output logic           full,
	input  wire logic      pop,
	output logic           head_valid,
	output kswr_cmd_t      head_cmd
);

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	kswr_cmd_t          slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/kswr_back.sv -----
// ---------------------------------------------------------------------------
// kswr_back
// Event FIFO: executes push and pop commands and registers each result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "key_scanner_with_repeat_fifo_assert.svh"

module kswr_back
	import kswr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	input  wire kswr_cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output kswr_out_t      out_data
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	kswr_ev_t            mem [QUEUE_DEPTH];
	kswr_ev_t            rdata_q;
	logic [PTR_W-1:0]    rd_q;
	logic [PTR_W-1:0]    wr_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   fill_nxt;

	logic                valid_s2;
	logic                pop_ok_s2;
	logic                empty_s2;
	logic                dropped_s2;
	logic [FILL_W-1:0]   fill_s2;

	logic                exec;
	logic                is_empty;
	logic                is_full;
	logic                do_rd;
	logic                do_wr;
	logic                pop_empty;
	logic                drop_ev;

	assign exec      = cmd_valid && (!valid_s2 || out_ready);
	assign cmd_pop   = exec;
	assign is_empty  = (fill_q == '0);
	assign is_full   = (fill_q >= FILL_W'(QUEUE_DEPTH));
	assign do_rd     = exec && cmd.is_pop && !is_empty;
	assign do_wr     = exec && !cmd.is_pop && cmd.has_ev && !is_full;
	assign pop_empty = exec && cmd.is_pop && is_empty;
	assign drop_ev   = exec && !cmd.is_pop && cmd.has_ev && is_full;

	always_comb begin
		fill_nxt = fill_q;
		if (do_rd) begin
			fill_nxt = fill_q - FILL_W'(1);
		end else if (do_wr) begin
			fill_nxt = fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_q] <= cmd.ev;
		end
		if (do_rd) begin
			rdata_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			wr_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_rd) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_wr) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (exec) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			pop_ok_s2  <= do_rd;
			empty_s2   <= pop_empty;
			dropped_s2 <= drop_ev;
			fill_s2    <= fill_nxt;
		end
	end

	assign out_valid = valid_s2;

	always_comb begin
		out_data.pop_code      = pop_ok_s2 ? (3'(rdata_q) + 3'd1) : POP_NONE;
		out_data.queue_empty   = empty_s2;
		out_data.event_dropped = dropped_s2;
		out_data.queued_count  = 5'(fill_s2);
	end

	`KS_ASSERT_NOW(a_empty_ptrs, fill_q == '0, rd_q == wr_q, "fifo empty with pointers apart")
	`KS_ASSERT_NEXT(a_pop_empty, pop_empty, empty_s2 && !pop_ok_s2, "empty pop not flagged")
	`KS_ASSERT_NEXT(a_drop_full, drop_ev, dropped_s2 && $stable(fill_q), "full push changed fifo")
	`KS_ASSERT_NEXT(a_pop_dec, do_rd, fill_q == ($past(fill_q) - FILL_W'(1)), "pop missed decrement")

endmodule

`default_nettype wire

// ----- rtl/core/key_scanner_with_repeat_fifo.sv -----
// ---------------------------------------------------------------------------
// key_scanner_with_repeat_fifo
// Keypad edge detect with auto-repeat for right/left and a bounded event FIFO.
// ---------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | in_data  : action, port_bits
//   out     | out_valid / out_ready| out_data : pop_code, queue_empty,
//           |                      |            event_dropped, queued_count
//   cfg     | cfg_we (no wait)     | cfg_idx, cfg_data
//
// One transaction per cycle sustained while out_ready holds high; the front
// classifies each accepted transaction into the command queue, and the FIFO
// executes it into the result register. The FIFO memory read is registered,
// which sets the result latency. Reset clears config to defaults, the held
// pattern, the stable count and all pointers; FIFO contents are not cleared. An
// output stall backs up the two-entry command queue, after which in_ready drops.
//
`default_nettype none

module key_scanner_with_repeat_fifo
	import kswr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire kswr_in_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output kswr_out_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	kswr_cfg_wr_t cfg;
	kswr_cmd_t    front_cmd;
	kswr_cmd_t    head_cmd;
	logic         q_full;
	logic         head_valid;
	logic         head_pop;
	logic         accept;

	// config port bundled for the front
	assign cfg.we   = cfg_we;
	assign cfg.idx  = cfg_idx;
	assign cfg.data = cfg_data;

	// front only needs room in the command queue
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	kswr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.in_data (in_data),
		.cmd     (front_cmd)
	);

	kswr_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_cmd   (front_cmd),
		.full       (q_full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back half: event FIFO and result register
	kswr_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (head_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- tb/key_report_checker.sv -----
// ---------------------------------------------------------------------------
// key_report_checker
// Watches the key scanner's channels, predicts each report from the accepted
// samples, pops and register writes, and compares the reports in order.
// ---------------------------------------------------------------------------
`default_nettype none

module key_report_checker import kswr_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire kswr_in_t              in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire kswr_out_t             out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         awaited
);

	timeunit 1ns;
	timeprecision 1ps;

	// register copies
	logic [PORT_WIDTH-1:0] key_mask;
	logic [THR_W-1:0]      threshold;
	logic [PORT_WIDTH-1:0] code_right;
	logic [PORT_WIDTH-1:0] code_left;
	logic [PORT_WIDTH-1:0] code_enter;
	logic [PORT_WIDTH-1:0] code_back;

	// scanner state
	logic [PORT_WIDTH-1:0] held_pat;
	logic [7:0]            stable_cnt;
	kswr_ev_t              key_events[$];

	kswr_out_t awaited_reports[$];
	kswr_out_t want;
	int        mismatch_count = 0;
	int        reports_awaited = 0;

	assign mismatches = mismatch_count;
	assign awaited    = reports_awaited;

	function automatic logic match_code(input logic [PORT_WIDTH-1:0] pat,
			input logic repeat_only, output kswr_ev_t ev);
		logic hit;
		hit = 1'b0;
		ev  = EV_RIGHT;
		if (pat != '0) begin
			hit = 1'b1;
			if (pat == code_right) begin
				ev = EV_RIGHT;
			end else if (pat == code_left) begin
				ev = EV_LEFT;
			end else if (!repeat_only && pat == code_enter) begin
				ev = EV_ENTER;
			end else if (!repeat_only && pat == code_back) begin
				ev = EV_BACK;
			end else begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

	function automatic kswr_out_t predict_report(input kswr_in_t item);
		kswr_out_t             rpt;
		logic [PORT_WIDTH-1:0] pressed;
		logic [PORT_WIDTH-1:0] trig;
		logic [PORT_WIDTH-1:0] last;
		kswr_ev_t              ev;
		logic                  hit;
		rpt = '0;
		rpt.pop_code = POP_NONE;
		if (item.action == ACT_POP) begin
			if (key_events.size() == 0) begin
				rpt.queue_empty = 1'b1;
			end else begin
				ev = key_events.pop_front();
				rpt.pop_code = 3'(ev) + 3'd1;
			end
		end else begin
			pressed  = (item.port_bits & key_mask) ^ key_mask;
			trig     = pressed & (pressed ^ held_pat);
			last     = held_pat;
			held_pat = pressed;
			if (pressed == last) begin
				if (stable_cnt != 8'hFF)
					stable_cnt = stable_cnt + 8'd1;
			end else begin
				stable_cnt = '0;
			end
			// auto-repeat only while held with no new press
			if (stable_cnt > threshold && pressed != '0 && trig == '0) begin
				stable_cnt = '0;
				hit = match_code(pressed & key_mask, 1'b1, ev);
			end else begin
				hit = match_code(trig & key_mask, 1'b0, ev);
			end
			if (hit) begin
				if (key_events.size() >= QUEUE_DEPTH)
					rpt.event_dropped = 1'b1;
				else
					key_events.push_back(ev);
			end
		end
		rpt.queued_count = 5'(key_events.size());
		return rpt;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s expected %0d got %0d", $time, name, exp_val, got_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mask   = RST_KEY_MASK;
			threshold  = RST_THRESHOLD;
			code_right = RST_CODE_RIGHT;
			code_left  = RST_CODE_LEFT;
			code_enter = RST_CODE_ENTER;
			code_back  = RST_CODE_BACK;
			held_pat   = '0;
			stable_cnt = '0;
			key_events.delete();
			awaited_reports.delete();
		end else begin
			if (cfg_we) begin
				case (kswr_cfg_idx_t'(cfg_idx))
					CFG_KEY_MASK:   key_mask   = cfg_data;
					CFG_THRESHOLD:  threshold  = cfg_data[THR_W-1:0];
					CFG_CODE_RIGHT: code_right = cfg_data;
					CFG_CODE_LEFT:  code_left  = cfg_data;
					CFG_CODE_ENTER: code_enter = cfg_data;
					CFG_CODE_BACK:  code_back  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				awaited_reports.push_back(predict_report(in_data));
			if (out_valid && out_ready) begin
				if (awaited_reports.size() == 0) begin
					$display("%0t: unexpected report expected none got %p", $time, out_data);
					mismatch_count++;
				end else begin
					want = awaited_reports.pop_front();
					check_field("pop_code", 8'(want.pop_code), 8'(out_data.pop_code));
					check_field("queue_empty", 8'(want.queue_empty),
						8'(out_data.queue_empty));
					check_field("event_dropped", 8'(want.event_dropped),
						8'(out_data.event_dropped));
					check_field("queued_count", 8'(want.queued_count),
						8'(out_data.queued_count));
				end
			end
		end
		reports_awaited = awaited_reports.size();
	end

endmodule

`default_nettype wire

// ----- tb/tb_key_scanner_with_repeat_fifo.sv -----
// ---------------------------------------------------------------------------
// tb_key_scanner_with_repeat_fifo
// Drives key samples and pops into the scanner under changing register
// settings and idle patterns; the checker beside the block judges each report.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_key_scanner_with_repeat_fifo import kswr_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES  = 8;

	// ------------------------------------------------------------------
	// clock, reset and DUT-facing signals (all known from time zero)
	// ------------------------------------------------------------------
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	kswr_in_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	kswr_out_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int mismatches;
	int awaited;

	// stimulus-side view of the registers, used only to shape key presses
	logic [PORT_WIDTH-1:0] mask_now = RST_KEY_MASK;
	logic [THR_W-1:0]      thr_now  = RST_THRESHOLD;
	logic [PORT_WIDTH-1:0] codes_now[4] = '{RST_CODE_RIGHT, RST_CODE_LEFT,
		RST_CODE_ENTER, RST_CODE_BACK};

	// idle percentages for the sender and the receiver
	int send_idle  = 0;
	int recv_stall = 0;

	int items_sent = 0;
	int cycle_count = 0;

	// per-phase shape: transaction count and share of pops mixed in
	int phase_len[NUM_PHASES] = '{200, 60, 220, 200, 180, 160, 200, 180};
	int phase_pop[NUM_PHASES] = '{30, 30, 20, 5, 25, 40, 25, 10};

	int                    ph;
	int                    phase_start;
	int                    sel;
	int                    len;
	int                    k;
	logic [PORT_WIDTH-1:0] pat;

	always #1 clk = ~clk;

	key_scanner_with_repeat_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	key_report_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// transaction helpers
	// ------------------------------------------------------------------

	// One input transaction. Gaps are taken at falling edges before valid
	// rises; valid stays high until the handshake, so back-to-back items with no
	// gap drawn keep valid high in between.
	task automatic send_item(input logic act, input logic [PORT_WIDTH-1:0] port);
		kswr_in_t item;
		item.action    = act;
		item.port_bits = port;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Sample with the given pressed pattern; bits outside the mask are noise.
	task automatic send_press(input logic [PORT_WIDTH-1:0] pressed);
		logic [PORT_WIDTH-1:0] noise;
		noise = PORT_WIDTH'($urandom);
		send_item(ACT_SAMPLE, (~pressed & mask_now) | (noise & ~mask_now));
	endtask

	// Register write; the block must be idle. The enable is dropped at the next
	// falling edge, so consecutive writes never collide in one step.
	task automatic write_reg(input kswr_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we   <= 1'b0;
		case (idx)
			CFG_KEY_MASK:   mask_now     = val;
			CFG_THRESHOLD:  thr_now      = val[THR_W-1:0];
			CFG_CODE_RIGHT: codes_now[0] = val;
			CFG_CODE_LEFT:  codes_now[1] = val;
			CFG_CODE_ENTER: codes_now[2] = val;
			CFG_CODE_BACK:  codes_now[3] = val;
			default: ;
		endcase
	endtask

	// Stop sending, let every report come back and let the pipeline settle
	// before touching registers or ending.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed: reset settings, one-hot keys on bits 7..10 ---
		send_item(ACT_POP, 16'hFFFF);           // pop from an empty queue
		send_item(ACT_SAMPLE, 16'hFFFF);        // all released
		send_item(ACT_SAMPLE, 16'hFF7F);        // right
		send_item(ACT_SAMPLE, 16'hFFFF);
		send_item(ACT_SAMPLE, 16'hFEFF);        // left
		send_item(ACT_SAMPLE, 16'hFFFF);
		send_item(ACT_SAMPLE, 16'hFDFF);        // enter
		send_item(ACT_SAMPLE, 16'hFFFF);
		send_item(ACT_SAMPLE, 16'hFBFF);        // back
		send_item(ACT_SAMPLE, 16'h0000);        // several keys: no code matches
		send_item(ACT_SAMPLE, 16'hFFFF);
		send_item(ACT_SAMPLE, 16'h0000);        // all pressed from released
		send_item(ACT_SAMPLE, 16'hFFFF);
		repeat (5)
			send_item(ACT_POP, PORT_WIDTH'($urandom)); // port ignored on a pop

		// --- random phases, each with its own settings and idle mix ---
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					// wide mask, repeat on every stable sample
					write_reg(CFG_KEY_MASK, 16'hFFFF);
					write_reg(CFG_THRESHOLD, 16'd0);
					for (k = 0; k < 4; k++)
						write_reg(kswr_cfg_idx_t'(CFG_CODE_RIGHT + k),
							16'd1 << $urandom_range(15));
				end
				1: begin
					// no button bits: nothing is ever pressed
					write_reg(CFG_KEY_MASK, 16'h0000);
					write_reg(CFG_THRESHOLD, 16'd3);
				end
				2: begin
					// never repeats; right and left share a code, enter is zero
					write_reg(CFG_KEY_MASK, PORT_WIDTH'($urandom) | 16'h0F00);
					write_reg(CFG_THRESHOLD, 16'd255);
					pat = (PORT_WIDTH'($urandom) & mask_now) | 16'h0100;
					write_reg(CFG_CODE_RIGHT, pat);
					write_reg(CFG_CODE_LEFT, pat);
					write_reg(CFG_CODE_ENTER, 16'h0000);
					write_reg(CFG_CODE_BACK, PORT_WIDTH'($urandom) & mask_now);
				end
				3: begin
					// multi-bit codes, fast repeat, few pops: queue fills up
					write_reg(CFG_KEY_MASK, 16'h00FF);
					write_reg(CFG_THRESHOLD, 16'd1);
					for (k = 0; k < 4; k++)
						write_reg(kswr_cfg_idx_t'(CFG_CODE_RIGHT + k),
							PORT_WIDTH'($urandom_range(1, 255)));
				end
				4: begin
					// all-pressed code, zero left code
					write_reg(CFG_KEY_MASK, 16'hFFFF);
					write_reg(CFG_THRESHOLD, 16'd2);
					write_reg(CFG_CODE_RIGHT, 16'hFFFF);
					write_reg(CFG_CODE_LEFT, 16'h0000);
					write_reg(CFG_CODE_ENTER, PORT_WIDTH'($urandom));
					write_reg(CFG_CODE_BACK, PORT_WIDTH'($urandom));
				end
				5: begin
					// mask change alone: held pattern stays from the old mask
					write_reg(CFG_KEY_MASK, 16'h0F0F);
				end
				6: begin
					write_reg(CFG_KEY_MASK, PORT_WIDTH'($urandom));
					write_reg(CFG_THRESHOLD, 16'($urandom_range(40)));
					for (k = 0; k < 4; k++)
						write_reg(kswr_cfg_idx_t'(CFG_CODE_RIGHT + k),
							PORT_WIDTH'($urandom) & mask_now);
				end
				default: begin
					// back to power-on values, few pops
					write_reg(CFG_KEY_MASK, RST_KEY_MASK);
					write_reg(CFG_THRESHOLD, 16'(RST_THRESHOLD));
					write_reg(CFG_CODE_RIGHT, RST_CODE_RIGHT);
					write_reg(CFG_CODE_LEFT, RST_CODE_LEFT);
					write_reg(CFG_CODE_ENTER, RST_CODE_ENTER);
					write_reg(CFG_CODE_BACK, RST_CODE_BACK);
				end
			endcase

			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 63; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 63; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase

			phase_start = items_sent;
			while (items_sent - phase_start < phase_len[ph]) begin
				sel = $urandom_range(99);
				if (sel < 55) begin
					// hold a key pattern: mostly a code, sometimes a
					// random subset or two codes at once
					k = $urandom_range(9);
					if (k < 7)
						pat = codes_now[$urandom_range(3)] & mask_now;
					else if (k < 9)
						pat = PORT_WIDTH'($urandom) & mask_now;
					else
						pat = (codes_now[$urandom_range(3)] |
							codes_now[$urandom_range(3)]) & mask_now;
					// long holds straddle the repeat threshold
					if ($urandom_range(9) == 0)
						len = $urandom_range(thr_now, thr_now + 12) + 1;
					else
						len = $urandom_range(1, 4);
					repeat (len) begin
						if ($urandom_range(99) < phase_pop[ph])
							send_item(ACT_POP, PORT_WIDTH'($urandom));
						send_press(pat);
					end
				end else if (sel < 70) begin
					repeat ($urandom_range(1, 3))
						send_press('0);
				end else if (sel < 88) begin
					// pop burst, long enough to hit an empty queue
					repeat ($urandom_range(1, 18))
						send_item(ACT_POP, PORT_WIDTH'($urandom));
				end else begin
					// raw noise on the port
					repeat ($urandom_range(1, 3))
						send_item(ACT_SAMPLE, PORT_WIDTH'($urandom));
				end
			end
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/kswr_pkg.sv
rtl/core/kswr_front.sv
rtl/core/kswr_cmdq.sv
rtl/core/kswr_back.sv
rtl/core/key_scanner_with_repeat_fifo.sv
tb/key_report_checker.sv
tb/tb_key_scanner_with_repeat_fifo.sv
